// File: rtl/core/sbsr_pkg.sv
// Shared types, constants and helpers for the six-axis bias/smooth/rotate block.
package sbsr_pkg;

    localparam int COUNT_BITS = 16;
    localparam int SUM_W      = 32 + COUNT_BITS;
    localparam int TGT_W      = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int AXES       = 6;
    localparam int AXIS_W     = 3;
    localparam int MUL_A_W    = 20;
    localparam int MUL_B_W    = 33;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = 56;
    localparam int V_W        = 33;
    localparam int ROT_W      = 36;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_CAPTURE = 2'd1,
        OP_FLAG    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS = 3'd6;

    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] cos_v;
        logic [15:0] sin_v;
        logic [31:0] gain_x;
        logic [31:0] gain_y;
        logic [31:0] gain_z;
        logic [15:0] points;
    } cfg_t;

    typedef struct packed {
        op_t                   op;
        logic                  flag;
        logic [AXES-1:0][31:0] x;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic in_div;
        logic div_busy;
    } back_sts_t;

    function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi_lim;
        logic signed [ACC_W-1:0] lo_lim;
        hi_lim = $signed({{(ACC_W-31){1'b0}}, {31{1'b1}}});
        lo_lim = $signed({{(ACC_W-31){1'b1}}, {31{1'b0}}});
        if (v > hi_lim)
            return 32'h7fff_ffff;
        else if (v < lo_lim)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

// File: rtl/core/sbsr_front.sv
// Front end: accepts items, drops unused codes, two-entry queue toward the back end.
module sbsr_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  sbsr_pkg::cmd_t cmd_in,
    output logic          q_valid,
    output sbsr_pkg::cmd_t q_data,
    input  logic          q_take
);
    import sbsr_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       keep;
    logic       take;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = slot_reg[rd_ptr_reg];
    // unused code is taken off the port and dropped here
    assign keep    = push && !full && (cmd_in.op != OP_NONE);
    assign take    = q_take && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (keep)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (take)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (keep && !take)
                cnt_reg <= cnt_reg + 2'd1;
            else if (take && !keep)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
            slot_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

// File: rtl/core/sbsr_div.sv
// Restoring serial divider, one quotient bit per cycle.
module sbsr_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [sbsr_pkg::SUM_W-1:0]         dividend,
    input  logic [sbsr_pkg::COUNT_BITS-1:0]    divisor,
    output logic                               busy,
    output logic                               done,
    output logic [sbsr_pkg::SUM_W-1:0]         quotient
);
    import sbsr_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]      quo_reg;
    logic [COUNT_BITS:0]   rem_reg;
    logic [COUNT_BITS-1:0] dvs_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  done_reg;
    logic [COUNT_BITS:0]   trial;
    logic                  fits;

    assign trial    = {rem_reg[COUNT_BITS-1:0], quo_reg[SUM_W-1]};
    assign fits     = (trial >= {1'b0, dvs_reg});
    assign busy     = (step_reg != '0);
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                step_reg <= STEP_W'(SUM_W);
            else if (busy)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy)
        begin
            rem_reg <= fits ? (trial - {1'b0, dvs_reg}) : trial;
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

endmodule

// File: rtl/core/sbsr_back.sv
// Back end: capture, bias division, smoothing, rotation and scaling on one shared multiplier.
module sbsr_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sbsr_pkg::cfg_t        cfg,
    input  logic                  q_valid,
    input  sbsr_pkg::cmd_t        q_data,
    output logic                  q_take,
    input  logic                  pop,
    output logic                  out_valid,
    output logic [5:0][31:0]      out_val,
    output logic                  out_bias_valid,
    output logic                  out_bias_latched,
    output sbsr_pkg::back_sts_t   sts
);
    import sbsr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV_START, S_DIV_WAIT, S_SMOOTH, S_SUB, S_ROT, S_SCALE, S_OUT
    } state_t;

    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    state_t                  state_reg;
    logic [31:0]             x_reg    [AXES];
    logic [31:0]             s_reg    [AXES];
    logic [31:0]             bias_reg [AXES];
    logic [SUM_W-1:0]        sum_reg  [AXES];
    logic signed [V_W-1:0]   v_reg    [AXES];
    logic signed [ROT_W-1:0] r_reg    [AXES];
    logic [31:0]             res_reg  [3];
    logic [COUNT_BITS-1:0]   cnt_reg;
    logic                    cap_reg;
    logic                    valid_reg;
    logic                    latched_reg;
    logic                    neg_reg;
    logic [AXIS_W-1:0]       axis_reg;
    logic [2:0]              step_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                    out_valid_reg;
    logic [31:0]             out_val_reg [AXES];
    logic                    out_bv_reg;
    logic                    out_bl_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   smooth_val;
    logic signed [ACC_W-1:0]   rot_x_val;
    logic signed [ACC_W-1:0]   rot_y_val;
    logic signed [ACC_W-1:0]   scale_val;
    logic signed [V_W-1:0]     px;
    logic signed [V_W-1:0]     py;
    logic signed [V_W-1:0]     pz;
    logic signed [ROT_W-1:0]   r_sel;
    logic [31:0]               gain_sel;
    logic [AXIS_W-1:0]         rot_base;
    logic [TGT_W-1:0]          target;
    logic                      below;
    logic [SUM_W-1:0]          sum_sel;
    logic                      sum_neg;
    logic [SUM_W-1:0]          dividend;
    logic                      div_start;
    logic                      div_busy;
    logic                      div_done;
    logic [SUM_W-1:0]          div_q;
    logic [31:0]               q32;
    logic                      start_item;
    logic                      last_axis;

    // capture target is bias_points limited to the counter range
    assign target = (TGT_W'(cfg.points) < TGT_W'(CMAX)) ? TGT_W'(cfg.points) : TGT_W'(CMAX);
    assign below  = (TGT_W'(cnt_reg) < target);

    assign start_item = (state_reg == S_IDLE) && q_valid &&
                        ((q_data.op != OP_SAMPLE) || !out_valid_reg);
    assign q_take     = start_item;
    assign last_axis  = (axis_reg == AXIS_W'(AXES - 1));

    // bias = sum / count, divided on |sum| and rounded half away from zero
    assign sum_sel   = sum_reg[axis_reg];
    assign sum_neg   = sum_sel[SUM_W-1];
    assign dividend  = (sum_neg ? (~sum_sel + 1'b1) : sum_sel) +
                       SUM_W'(cnt_reg >> 1);
    assign div_start = (state_reg == S_DIV_START) && (cnt_reg != '0);
    assign q32       = div_q[31:0];

    sbsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (cnt_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign px       = axis_reg[0] ? v_reg[3] : v_reg[0];
    assign py       = axis_reg[0] ? v_reg[4] : v_reg[1];
    assign pz       = axis_reg[0] ? v_reg[5] : v_reg[2];
    assign rot_base = axis_reg[0] ? AXIS_W'(3) : AXIS_W'(0);
    assign r_sel    = r_reg[axis_reg];
    assign gain_sel = (axis_reg == AXIS_W'(0)) ? cfg.gain_x :
                      (axis_reg == AXIS_W'(1)) ? cfg.gain_y : cfg.gain_z;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SMOOTH:
            begin
                if (step_reg == 3'd0)
                begin
                    mul_a = $signed({4'b0, cfg.alpha});
                    mul_b = $signed({x_reg[axis_reg][31], x_reg[axis_reg]});
                end
                else
                begin
                    mul_a = $signed(20'd65536 - {4'b0, cfg.alpha});
                    mul_b = $signed({s_reg[axis_reg][31], s_reg[axis_reg]});
                end
            end
            S_ROT:
            begin
                case (step_reg)
                    3'd0:    begin mul_a = MUL_A_W'($signed(cfg.cos_v)); mul_b = px; end
                    3'd1:    begin mul_a = MUL_A_W'($signed(cfg.sin_v)); mul_b = py; end
                    3'd2:    begin mul_a = MUL_A_W'($signed(cfg.sin_v)); mul_b = px; end
                    default: begin mul_a = MUL_A_W'($signed(cfg.cos_v)); mul_b = py; end
                endcase
            end
            S_SCALE:
            begin
                // split r into a signed high 20 bits and an unsigned low 16 bits
                mul_a = (step_reg == 3'd0) ? MUL_A_W'(r_sel >>> 16)
                                           : $signed({4'b0, r_sel[15:0]});
                mul_b = $signed({gain_sel[31], gain_sel});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next  = mul_a * mul_b;
    assign prod_ext   = ACC_W'(prod_reg);
    assign smooth_val = (acc_reg + prod_ext + 56'sd32768) >>> 16;
    assign rot_x_val  = (acc_reg - prod_ext + 56'sd8192) >>> 14;
    assign rot_y_val  = (acc_reg + prod_ext + 56'sd8192) >>> 14;
    assign scale_val  = acc_reg + ((prod_ext + 56'sd32768) >>> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            cap_reg       <= 1'b0;
            valid_reg     <= 1'b0;
            latched_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            axis_reg      <= '0;
            step_reg      <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                s_reg[i]    <= '0;
                bias_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
        end
        else
        begin
            if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start_item)
                    begin
                        unique case (q_data.op)
                            OP_CAPTURE:
                            begin
                                cap_reg   <= 1'b1;
                                valid_reg <= 1'b0;
                                cnt_reg   <= '0;
                                for (int i = 0; i < AXES; i++)
                                    sum_reg[i] <= '0;
                            end
                            OP_FLAG:
                                cap_reg <= q_data.flag;
                            default:
                            begin
                                for (int i = 0; i < AXES; i++)
                                    x_reg[i] <= q_data.x[i];
                                latched_reg <= 1'b0;
                                axis_reg    <= '0;
                                step_reg    <= '0;
                                if (cap_reg && !below)
                                begin
                                    cap_reg     <= 1'b0;
                                    valid_reg   <= 1'b1;
                                    latched_reg <= 1'b1;
                                    state_reg   <= S_DIV_START;
                                end
                                else
                                begin
                                    if (cap_reg)
                                    begin
                                        for (int i = 0; i < AXES; i++)
                                            sum_reg[i] <= sum_reg[i] +
                                                {{(SUM_W-32){q_data.x[i][31]}}, q_data.x[i]};
                                        cnt_reg <= cnt_reg + 1'b1;
                                    end
                                    state_reg <= (cfg.alpha != '0) ? S_SMOOTH : S_SUB;
                                end
                            end
                        endcase
                    end
                end
                S_DIV_START:
                begin
                    neg_reg <= sum_neg;
                    if (cnt_reg == '0)
                    begin
                        bias_reg[axis_reg] <= '0;
                        axis_reg           <= last_axis ? '0 : axis_reg + 1'b1;
                        if (last_axis)
                            state_reg <= (cfg.alpha != '0) ? S_SMOOTH : S_SUB;
                    end
                    else
                        state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        bias_reg[axis_reg] <= neg_reg ? (~q32 + 1'b1) : q32;
                        axis_reg           <= last_axis ? '0 : axis_reg + 1'b1;
                        state_reg          <= last_axis ?
                            ((cfg.alpha != '0) ? S_SMOOTH : S_SUB) : S_DIV_START;
                    end
                end
                S_SMOOTH:
                begin
                    prod_reg <= prod_next;
                    acc_reg  <= prod_ext;
                    if (step_reg == 3'd2)
                    begin
                        s_reg[axis_reg] <= smooth_val[31:0];
                        step_reg        <= '0;
                        axis_reg        <= last_axis ? '0 : axis_reg + 1'b1;
                        if (last_axis)
                            state_reg <= S_SUB;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                S_SUB:
                begin
                    for (int i = 0; i < AXES; i++)
                        v_reg[i] <= $signed({(cfg.alpha != '0) ? s_reg[i][31] : x_reg[i][31],
                                             (cfg.alpha != '0) ? s_reg[i] : x_reg[i]})
                                  - $signed({bias_reg[i][31], bias_reg[i]});
                    axis_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= S_ROT;
                end
                S_ROT:
                begin
                    prod_reg <= prod_next;
                    acc_reg  <= prod_ext;
                    if (step_reg == 3'd2)
                        r_reg[rot_base] <= rot_x_val[ROT_W-1:0];
                    if (step_reg == 3'd4)
                    begin
                        r_reg[rot_base + AXIS_W'(1)] <= rot_y_val[ROT_W-1:0];
                        r_reg[rot_base + AXIS_W'(2)] <= ROT_W'(pz);
                        step_reg <= '0;
                        if (axis_reg[0])
                        begin
                            axis_reg  <= '0;
                            state_reg <= S_SCALE;
                        end
                        else
                            axis_reg <= axis_reg + 1'b1;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                S_SCALE:
                begin
                    prod_reg <= prod_next;
                    acc_reg  <= prod_ext;
                    if (step_reg == 3'd2)
                    begin
                        res_reg[axis_reg[1:0]] <= sat32(scale_val);
                        step_reg               <= '0;
                        if (axis_reg == AXIS_W'(2))
                            state_reg <= S_OUT;
                        else
                            axis_reg <= axis_reg + 1'b1;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                S_OUT:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        out_val_reg[i]     <= res_reg[i];
                        out_val_reg[i + 3] <= sat32(ACC_W'(r_reg[i + 3]));
                    end
                    out_bv_reg    <= valid_reg;
                    out_bl_reg    <= latched_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
            out_val[i] = out_val_reg[i];
    end

    assign out_valid        = out_valid_reg;
    assign out_bias_valid   = out_bv_reg;
    assign out_bias_latched = out_bl_reg;
    assign sts.busy         = (state_reg != S_IDLE);
    assign sts.in_div       = (state_reg == S_DIV_WAIT) || (state_reg == S_DIV_START);
    assign sts.div_busy     = div_busy;

endmodule

// File: rtl/core/six_axis_bias_smooth_rotate.sv
// Top level of the six-axis force/torque bias, smoothing and yaw rotation block.
// Six-axis Q16.16 force/torque corrector with queue-style ports on both sides. Items
// are pushed while full is low; results are popped while empty is low. Operation 0
// is a sample and yields one result; operation 1 starts a bias capture (clears
// sums and count, drops bias_valid); operation 2 writes capture_flag into the
// capture enable; operation 3 is taken and discarded. A two-entry queue sits in
// front of the sequencer, so pushes continue while a result waits to be popped.
// Every multiply runs through one shared 20x33 multiplier: a sample passes through
// smoothing (when alpha is nonzero), rotation and gain scaling in turn. The sample
// that closes a capture also divides the six sums on a serial divider. Configuration
// (cfg_we/cfg_index/cfg_data) is taken at once and must only be written while idle.
module six_axis_bias_smooth_rotate (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [1:0]                       operation,
    input  logic                             capture_flag,
    input  logic signed [31:0]               force_x_in,
    input  logic signed [31:0]               force_y_in,
    input  logic signed [31:0]               force_z_in,
    input  logic signed [31:0]               torque_x_in,
    input  logic signed [31:0]               torque_y_in,
    input  logic signed [31:0]               torque_z_in,
    output logic                             empty,
    input  logic                             pop,
    output logic signed [31:0]               force_x_out,
    output logic signed [31:0]               force_y_out,
    output logic signed [31:0]               force_z_out,
    output logic signed [31:0]               torque_x_out,
    output logic signed [31:0]               torque_y_out,
    output logic signed [31:0]               torque_z_out,
    output logic                             bias_valid,
    output logic                             bias_latched,
    input  logic                             cfg_we,
    input  logic [sbsr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data
);
    import sbsr_pkg::*;

    cfg_t            cfg_reg;
    cmd_t            cmd_in;
    cmd_t            q_data;
    logic            q_valid;
    logic            q_take;
    logic            out_valid;
    logic [5:0][31:0] out_val;
    back_sts_t       sts;

    // register writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha  <= 16'd0;
            cfg_reg.cos_v  <= 16'd16384;
            cfg_reg.sin_v  <= 16'd0;
            cfg_reg.gain_x <= 32'd65536;
            cfg_reg.gain_y <= 32'd65536;
            cfg_reg.gain_z <= 32'd65536;
            cfg_reg.points <= 16'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ALPHA:  cfg_reg.alpha  <= cfg_data[15:0];
                REG_COS:    cfg_reg.cos_v  <= cfg_data[15:0];
                REG_SIN:    cfg_reg.sin_v  <= cfg_data[15:0];
                REG_GAIN_X: cfg_reg.gain_x <= cfg_data;
                REG_GAIN_Y: cfg_reg.gain_y <= cfg_data;
                REG_GAIN_Z: cfg_reg.gain_z <= cfg_data;
                REG_POINTS: cfg_reg.points <= cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    assign cmd_in.op   = op_t'(operation);
    assign cmd_in.flag = capture_flag;
    assign cmd_in.x    = {torque_z_in, torque_y_in, torque_x_in,
                          force_z_in, force_y_in, force_x_in};

    sbsr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .cmd_in  (cmd_in),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_take  (q_take)
    );

    sbsr_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .q_valid          (q_valid),
        .q_data           (q_data),
        .q_take           (q_take),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_val          (out_val),
        .out_bias_valid   (bias_valid),
        .out_bias_latched (bias_latched),
        .sts              (sts)
    );

    assign empty        = !out_valid;
    assign force_x_out  = out_val[0];
    assign force_y_out  = out_val[1];
    assign force_z_out  = out_val[2];
    assign torque_x_out = out_val[3];
    assign torque_y_out = out_val[4];
    assign torque_z_out = out_val[5];

`ifndef ASSERT_OFF
    // a result that latched a bias must also report the bias as valid
    a_latch_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && bias_latched) |-> bias_valid)
        else $error("bias_latched without bias_valid");

    // the divider only runs while the sequencer is in the bias division phase
    a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_busy |-> sts.in_div)
        else $error("divider busy outside division phase");

    // the sequencer only pulls from the queue when idle
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> (q_valid && !sts.busy))
        else $error("queue read while sequencer busy");
`endif

endmodule
